// ===== rtl/pcb_pkg.sv =====
// ----------------------------------------------------------------------------
// pcb_pkg
// Shared types, codes and saturating helpers for the particle collide block.
// ----------------------------------------------------------------------------
package pcb_pkg;

  localparam int unsigned MAX_PARTICLES_DEF = 1024;

  localparam logic [15:0] WIDTH_RST  = 16'd640;
  localparam logic [15:0] HEIGHT_RST = 16'd480;
  localparam logic [31:0] VMAX_RST   = 32'd6553600;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_VMAX   = 2'd2;

  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  localparam int unsigned SQRT_STEPS = 26;
  localparam int unsigned DIV_STEPS  = 25;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ACCEL   = 2'd1,
    CMD_COLLIDE = 2'd2,
    CMD_MOVE    = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_RD_A,
    OP_CAP_A,
    OP_CAP_B,
    OP_MUL_ACCX,
    OP_ADD_VX,
    OP_MUL_ACCY,
    OP_ADD_VY,
    OP_BOUNCE,
    OP_MUL_VX,
    OP_ADD_PX,
    OP_MUL_VY,
    OP_ADD_PY,
    OP_DIFF,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_SUM,
    OP_SQRT,
    OP_MUL_PX,
    OP_DIV_LD,
    OP_DIV,
    OP_MUL_PY,
    OP_APPLY,
    OP_WB_A,
    OP_WB_B,
    OP_DONE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic a_oob;
    logic b_oob;
    logic near;
    logic push;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = S32_MAX;
    else if (v < -48'sd2147483648) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] neg32(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == S32_MIN) r = S32_MAX;
    else r = -v;
    return r;
  endfunction

endpackage

// ===== rtl/pcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcb_ctrl
// Command sequencer: walks each command through the datapath steps.
// ----------------------------------------------------------------------------
module pcb_ctrl import pcb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy_o
);

  typedef enum logic [28:0] {
    S_IDLE   = 29'd1 << 0,
    S_DECODE = 29'd1 << 1,
    S_RDA    = 29'd1 << 2,
    S_CAPA   = 29'd1 << 3,
    S_CAPB   = 29'd1 << 4,
    S_ACC_MX = 29'd1 << 5,
    S_ACC_AX = 29'd1 << 6,
    S_ACC_MY = 29'd1 << 7,
    S_ACC_AY = 29'd1 << 8,
    S_BOUNCE = 29'd1 << 9,
    S_MV_MX  = 29'd1 << 10,
    S_MV_AX  = 29'd1 << 11,
    S_MV_MY  = 29'd1 << 12,
    S_MV_AY  = 29'd1 << 13,
    S_DIFF   = 29'd1 << 14,
    S_SQ_X   = 29'd1 << 15,
    S_SQ_Y   = 29'd1 << 16,
    S_SQ_SUM = 29'd1 << 17,
    S_SQRT   = 29'd1 << 18,
    S_MUL_PX = 29'd1 << 19,
    S_DIV_LX = 29'd1 << 20,
    S_DIVX   = 29'd1 << 21,
    S_MUL_PY = 29'd1 << 22,
    S_DIV_LY = 29'd1 << 23,
    S_DIVY   = 29'd1 << 24,
    S_APPLY  = 29'd1 << 25,
    S_WB_A   = 29'd1 << 26,
    S_WB_B   = 29'd1 << 27,
    S_DONE   = 29'd1 << 28
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ctrl_o.op = OP_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.op = OP_LATCH;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.a_oob) state_d = S_DONE;
        else if (stat_i.cmd == CMD_LOAD) state_d = S_WB_A;
        else state_d = S_RDA;
      end
      S_RDA: begin
        ctrl_o.op = OP_RD_A;
        state_d   = S_CAPA;
      end
      S_CAPA: begin
        ctrl_o.op = OP_CAP_A;
        unique case (stat_i.cmd)
          CMD_ACCEL:   state_d = S_ACC_MX;
          CMD_MOVE:    state_d = S_BOUNCE;
          CMD_COLLIDE: state_d = stat_i.b_oob ? S_DONE : S_CAPB;
          default:     state_d = S_DONE;
        endcase
      end
      S_CAPB: begin
        ctrl_o.op = OP_CAP_B;
        state_d   = S_DIFF;
      end
      S_ACC_MX: begin
        ctrl_o.op = OP_MUL_ACCX;
        state_d   = S_ACC_AX;
      end
      S_ACC_AX: begin
        ctrl_o.op = OP_ADD_VX;
        state_d   = S_ACC_MY;
      end
      S_ACC_MY: begin
        ctrl_o.op = OP_MUL_ACCY;
        state_d   = S_ACC_AY;
      end
      S_ACC_AY: begin
        ctrl_o.op = OP_ADD_VY;
        state_d   = S_WB_A;
      end
      S_BOUNCE: begin
        ctrl_o.op = OP_BOUNCE;
        state_d   = S_MV_MX;
      end
      S_MV_MX: begin
        ctrl_o.op = OP_MUL_VX;
        state_d   = S_MV_AX;
      end
      S_MV_AX: begin
        ctrl_o.op = OP_ADD_PX;
        state_d   = S_MV_MY;
      end
      S_MV_MY: begin
        ctrl_o.op = OP_MUL_VY;
        state_d   = S_MV_AY;
      end
      S_MV_AY: begin
        ctrl_o.op = OP_ADD_PY;
        state_d   = S_WB_A;
      end
      S_DIFF: begin
        ctrl_o.op = OP_DIFF;
        state_d   = S_SQ_X;
      end
      S_SQ_X: begin
        ctrl_o.op = OP_SQ_X;
        state_d   = stat_i.near ? S_SQ_Y : S_DONE;
      end
      S_SQ_Y: begin
        ctrl_o.op = OP_SQ_Y;
        state_d   = S_SQ_SUM;
      end
      S_SQ_SUM: begin
        ctrl_o.op = OP_SQ_SUM;
        cnt_d     = 5'(SQRT_STEPS - 1);
        state_d   = S_SQRT;
      end
      S_SQRT: begin
        ctrl_o.op = OP_SQRT;
        if (cnt_q == '0) state_d = S_MUL_PX;
        else cnt_d = cnt_q - 5'd1;
      end
      S_MUL_PX: begin
        ctrl_o.op = OP_MUL_PX;
        state_d   = stat_i.push ? S_DIV_LX : S_DONE;
      end
      S_DIV_LX: begin
        ctrl_o.op = OP_DIV_LD;
        cnt_d     = 5'(DIV_STEPS - 1);
        state_d   = S_DIVX;
      end
      S_DIVX: begin
        ctrl_o.op = OP_DIV;
        if (cnt_q == '0) state_d = S_MUL_PY;
        else cnt_d = cnt_q - 5'd1;
      end
      S_MUL_PY: begin
        ctrl_o.op = OP_MUL_PY;
        state_d   = S_DIV_LY;
      end
      S_DIV_LY: begin
        ctrl_o.op = OP_DIV_LD;
        cnt_d     = 5'(DIV_STEPS - 1);
        state_d   = S_DIVY;
      end
      S_DIVY: begin
        ctrl_o.op = OP_DIV;
        if (cnt_q == '0) state_d = S_APPLY;
        else cnt_d = cnt_q - 5'd1;
      end
      S_APPLY: begin
        ctrl_o.op = OP_APPLY;
        state_d   = S_WB_A;
      end
      S_WB_A: begin
        ctrl_o.op = OP_WB_A;
        state_d   = (stat_i.cmd == CMD_COLLIDE) ? S_WB_B : S_DONE;
      end
      S_WB_B: begin
        ctrl_o.op = OP_WB_B;
        state_d   = S_DONE;
      end
      S_DONE: begin
        ctrl_o.op = OP_DONE;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/pcb_dp.sv =====
// ----------------------------------------------------------------------------
// pcb_dp
// Datapath: particle stores, shared multiplier, root and divide units.
// ----------------------------------------------------------------------------
module pcb_dp import pcb_pkg::*; #(
  parameter int unsigned MAX_PARTICLES = MAX_PARTICLES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  output stat_t              stat_o,
  input  logic [15:0]        width_i,
  input  logic [15:0]        height_i,
  input  logic signed [31:0] vmax_i,
  input  logic [1:0]         cmd_i,
  input  logic [9:0]         index_a_i,
  input  logic [9:0]         index_b_i,
  input  logic [19:0]        dt_i,
  input  logic signed [31:0] load_pos_x_i,
  input  logic signed [31:0] load_pos_y_i,
  input  logic signed [31:0] load_vel_x_i,
  input  logic signed [31:0] load_vel_y_i,
  input  logic signed [31:0] load_acc_x_i,
  input  logic signed [31:0] load_acc_y_i,
  input  logic [23:0]        load_radius_i,
  output logic               done_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic               collided_o
);

  localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  logic [31:0] px_mem [MAX_PARTICLES];
  logic [31:0] py_mem [MAX_PARTICLES];
  logic [31:0] vx_mem [MAX_PARTICLES];
  logic [31:0] vy_mem [MAX_PARTICLES];
  logic [31:0] ax_mem [MAX_PARTICLES];
  logic [31:0] ay_mem [MAX_PARTICLES];
  logic [23:0] r_mem  [MAX_PARTICLES];

  cmd_e               cmd_q;
  logic [16:0]        ia_q, ib_q;
  logic [19:0]        dt_q;
  logic signed [31:0] pxa_q, pya_q, vxa_q, vya_q, axa_q, aya_q;
  logic [23:0]        ra_q;
  logic signed [31:0] pxb_q, pyb_q, vxb_q, vyb_q;
  logic [23:0]        rb_q;
  logic signed [31:0] rd_px_q, rd_py_q, rd_vx_q, rd_vy_q, rd_ax_q, rd_ay_q;
  logic [23:0]        rd_r_q;

  logic               dxneg_q, dyneg_q;
  logic [32:0]        adx_q, ady_q;
  logic [24:0]        r_q;
  logic [49:0]        sqx_q;
  logic [51:0]        x_q, res_q, bit_q;
  logic [50:0]        rem_q, dsh_q;
  logic [24:0]        quo_q, qx_q;
  logic signed [58:0] prod_q;
  logic               coll_q;
  logic               done_q;

  logic [AW-1:0]      addr_a, addr_b, mem_addr;
  logic               we_all, we_pv, wsel_b;
  logic signed [32:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [47:0] tdt;
  logic signed [32:0] dx, dy;
  logic [25:0]        dlen;
  logic [24:0]        amount;
  logic [51:0]        sq_t;
  logic signed [47:0] sx, sy;
  logic signed [47:0] wall_x, wall_y;

  assign addr_a   = ia_q[AW-1:0];
  assign addr_b   = ib_q[AW-1:0];
  assign wsel_b   = (ctrl_i.op == OP_WB_B);
  assign mem_addr = (ctrl_i.op == OP_CAP_A || wsel_b) ? addr_b : addr_a;
  assign we_all   = (ctrl_i.op == OP_WB_A);
  assign we_pv    = we_all || wsel_b;

  assign dlen   = res_q[25:0];
  assign amount = r_q - res_q[24:0];
  assign tdt    = 48'(prod_q >>> 16);
  assign dx     = 33'(pxa_q) - 33'(pxb_q);
  assign dy     = 33'(pya_q) - 33'(pyb_q);
  assign sq_t   = res_q + bit_q;
  assign sx     = dxneg_q ? -$signed({23'd0, qx_q}) : $signed({23'd0, qx_q});
  assign sy     = dyneg_q ? -$signed({23'd0, quo_q}) : $signed({23'd0, quo_q});
  assign wall_x = $signed({32'd0, width_i});
  assign wall_y = $signed({32'd0, height_i});

  assign stat_o.cmd   = cmd_q;
  assign stat_o.a_oob = (ia_q >= 17'(MAX_PARTICLES));
  assign stat_o.b_oob = (ib_q >= 17'(MAX_PARTICLES));
  assign stat_o.near  = (adx_q < 33'(r_q)) && (ady_q < 33'(r_q));
  assign stat_o.push  = (dlen < 26'(r_q)) && (dlen != '0);

  always_ff @(posedge clk_i) begin
    if (we_pv) begin
      px_mem[mem_addr] <= wsel_b ? pxb_q : pxa_q;
      py_mem[mem_addr] <= wsel_b ? pyb_q : pya_q;
      vx_mem[mem_addr] <= wsel_b ? vxb_q : vxa_q;
      vy_mem[mem_addr] <= wsel_b ? vyb_q : vya_q;
    end
    if (we_all) begin
      ax_mem[mem_addr] <= axa_q;
      ay_mem[mem_addr] <= aya_q;
      r_mem[mem_addr]  <= ra_q;
    end
    rd_px_q <= px_mem[mem_addr];
    rd_py_q <= py_mem[mem_addr];
    rd_vx_q <= vx_mem[mem_addr];
    rd_vy_q <= vy_mem[mem_addr];
    rd_ax_q <= ax_mem[mem_addr];
    rd_ay_q <= ay_mem[mem_addr];
    rd_r_q  <= r_mem[mem_addr];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl_i.op)
      OP_MUL_ACCX: begin mul_a = 33'(axa_q); mul_b = {6'd0, dt_q}; end
      OP_MUL_ACCY: begin mul_a = 33'(aya_q); mul_b = {6'd0, dt_q}; end
      OP_MUL_VX:   begin mul_a = 33'(vxa_q); mul_b = {6'd0, dt_q}; end
      OP_MUL_VY:   begin mul_a = 33'(vya_q); mul_b = {6'd0, dt_q}; end
      OP_SQ_X:     begin mul_a = {8'd0, adx_q[24:0]}; mul_b = {1'b0, adx_q[24:0]}; end
      OP_SQ_Y:     begin mul_a = {8'd0, ady_q[24:0]}; mul_b = {1'b0, ady_q[24:0]}; end
      OP_MUL_PX:   begin mul_a = {8'd0, adx_q[24:0]}; mul_b = {1'b0, amount}; end
      OP_MUL_PY:   begin mul_a = {8'd0, ady_q[24:0]}; mul_b = {1'b0, amount}; end
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (ctrl_i.op)
      OP_LATCH: begin
        cmd_q <= cmd_e'(cmd_i);
        ia_q  <= {7'd0, index_a_i};
        ib_q  <= {7'd0, index_b_i};
        dt_q  <= dt_i;
        pxa_q <= load_pos_x_i;
        pya_q <= load_pos_y_i;
        vxa_q <= load_vel_x_i;
        vya_q <= load_vel_y_i;
        axa_q <= load_acc_x_i;
        aya_q <= load_acc_y_i;
        ra_q  <= load_radius_i;
      end
      OP_CAP_A: begin
        pxa_q <= rd_px_q;
        pya_q <= rd_py_q;
        vxa_q <= rd_vx_q;
        vya_q <= rd_vy_q;
        axa_q <= rd_ax_q;
        aya_q <= rd_ay_q;
        ra_q  <= rd_r_q;
      end
      OP_CAP_B: begin
        pxb_q <= rd_px_q;
        pyb_q <= rd_py_q;
        vxb_q <= rd_vx_q;
        vyb_q <= rd_vy_q;
        rb_q  <= rd_r_q;
      end
      OP_ADD_VX: if (vxa_q < vmax_i) vxa_q <= sat32(48'(vxa_q) + tdt);
      OP_ADD_VY: if (vya_q < vmax_i) vya_q <= sat32(48'(vya_q) + tdt);
      OP_BOUNCE: begin
        if (48'(pxa_q) > (wall_x <<< 16)) begin
          vxa_q <= neg32(vxa_q);
          pxa_q <= sat32((wall_x - 48'sd1) <<< 16);
        end else if (pxa_q < 0) begin
          vxa_q <= neg32(vxa_q);
          pxa_q <= Q_ONE;
        end
        if (48'(pya_q) > (wall_y <<< 16)) begin
          vya_q <= neg32(vya_q);
          pya_q <= sat32((wall_y - 48'sd1) <<< 16);
        end else if (pya_q < 0) begin
          vya_q <= neg32(vya_q);
          pya_q <= Q_ONE;
        end
      end
      OP_ADD_PX: pxa_q <= sat32(48'(pxa_q) + tdt);
      OP_ADD_PY: pya_q <= sat32(48'(pya_q) + tdt);
      OP_DIFF: begin
        dxneg_q <= dx[32];
        dyneg_q <= dy[32];
        adx_q   <= dx[32] ? 33'(-dx) : 33'(dx);
        ady_q   <= dy[32] ? 33'(-dy) : 33'(dy);
        r_q     <= 25'(ra_q) + 25'(rb_q);
      end
      OP_SQ_Y: sqx_q <= prod_q[49:0];
      OP_SQ_SUM: begin
        x_q   <= 52'(sqx_q) + 52'(prod_q[49:0]);
        res_q <= '0;
        bit_q <= 52'd1 << 50;
      end
      OP_SQRT: begin
        if (x_q >= sq_t) begin
          x_q   <= x_q - sq_t;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_DIV_LD: begin
        rem_q <= {1'b0, prod_q[49:0]};
        dsh_q <= 51'(dlen) << 24;
        quo_q <= '0;
      end
      OP_DIV: begin
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[23:0], 1'b1};
        end else begin
          quo_q <= {quo_q[23:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
      end
      OP_MUL_PY: qx_q <= quo_q;
      OP_APPLY: begin
        pxa_q <= sat32(48'(pxa_q) + sx);
        pxb_q <= sat32(48'(pxb_q) - sx);
        pya_q <= sat32(48'(pya_q) + sy);
        pyb_q <= sat32(48'(pyb_q) - sy);
        if ({adx_q, 1'b0} >= 34'(r_q)) begin
          vxa_q <= neg32(vxa_q);
          vxb_q <= neg32(vxb_q);
        end
        if ({ady_q, 1'b0} >= 34'(r_q)) begin
          vya_q <= neg32(vya_q);
          vyb_q <= neg32(vyb_q);
        end
      end
      OP_DONE: begin
        pos_x_o <= stat_o.a_oob ? '0 : pxa_q;
        pos_y_o <= stat_o.a_oob ? '0 : pya_q;
        vel_x_o <= stat_o.a_oob ? '0 : vxa_q;
        vel_y_o <= stat_o.a_oob ? '0 : vya_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q     <= 1'b0;
      coll_q     <= 1'b0;
      collided_o <= 1'b0;
    end else begin
      done_q <= (ctrl_i.op == OP_DONE);
      if (ctrl_i.op == OP_LATCH) coll_q <= 1'b0;
      else if (ctrl_i.op == OP_MUL_PX) coll_q <= (dlen < 26'(r_q));
      if (ctrl_i.op == OP_DONE) collided_o <= coll_q && !stat_o.a_oob;
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/particle_collide_bounce_step.sv =====
// ----------------------------------------------------------------------------
// particle_collide_bounce_step
// Particle store with circle collision response, wall bounce and motion.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd_i, indices, dt_i and load fields with start_i;
//   the command is taken on a clock edge where start_i is high and busy_o low.
//   Result channel: done_o is high for one cycle with pos, vel and collided of
//   particle index_a after the command; the receiver must take it then.
//   Commands are load, accelerate, move and collide. Collide uses a 26-step
//   integer square root and two 25-step restoring divides, and all products
//   use one shared multiplier; one command is in flight.
//   A new command may be taken in the cycle that done_o is high.
//   Configuration over APB (word addresses 0, 4, 8: width, height, velocity
//   cap); write only while busy_o is low and no result is pending.
//   Reset returns the sequencer to idle and the registers to 640, 480 and
//   100.0; particle stores are undefined until loaded. There is no back
//   pressure on the result channel.
// ----------------------------------------------------------------------------
module particle_collide_bounce_step import pcb_pkg::*; #(
  parameter int unsigned MAX_PARTICLES = MAX_PARTICLES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         cmd_i,
  input  logic [9:0]         index_a_i,
  input  logic [9:0]         index_b_i,
  input  logic [19:0]        dt_i,
  input  logic signed [31:0] load_pos_x_i,
  input  logic signed [31:0] load_pos_y_i,
  input  logic signed [31:0] load_vel_x_i,
  input  logic signed [31:0] load_vel_y_i,
  input  logic signed [31:0] load_acc_x_i,
  input  logic signed [31:0] load_acc_y_i,
  input  logic [23:0]        load_radius_i,
  output logic               done_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic               collided_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0]        width_q, height_q;
  logic signed [31:0] vmax_q;
  logic               cfg_wr;
  ctrl_t              ctrl;
  stat_t              stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      vmax_q   <= VMAX_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_q  <= pwdata[15:0];
        REG_HEIGHT: height_q <= pwdata[15:0];
        REG_VMAX:   vmax_q   <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {16'd0, width_q};
      REG_HEIGHT: prdata = {16'd0, height_q};
      REG_VMAX:   prdata = vmax_q;
      default:    prdata = '0;
    endcase
  end

  pcb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  pcb_dp #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .width_i       (width_q),
    .height_i      (height_q),
    .vmax_i        (vmax_q),
    .cmd_i         (cmd_i),
    .index_a_i     (index_a_i),
    .index_b_i     (index_b_i),
    .dt_i          (dt_i),
    .load_pos_x_i  (load_pos_x_i),
    .load_pos_y_i  (load_pos_y_i),
    .load_vel_x_i  (load_vel_x_i),
    .load_vel_y_i  (load_vel_y_i),
    .load_acc_x_i  (load_acc_x_i),
    .load_acc_y_i  (load_acc_y_i),
    .load_radius_i (load_radius_i),
    .done_o        (done_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .vel_x_o       (vel_x_o),
    .vel_y_o       (vel_y_o),
    .collided_o    (collided_o)
  );

endmodule
